FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of the position controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define DBSPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("controller assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define DBSPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("controller assertion failed");

`endif

FILE: hdl/dbspc_pkg.sv
// ----------------------------------------------------------------------------
// dbspc_pkg
// Types, widths and constants of the deadband step position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dbspc_pkg;

  localparam int unsigned NumAxes   = 2;
  localparam int unsigned AxisW     = 1;
  localparam int unsigned PosW      = 15;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned StepW     = 16;
  localparam int unsigned GainW     = 16;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 3;

  // 100 percent in Q7.8
  localparam logic [PosW-1:0] SetpointMax = 15'd25600;

  localparam logic             RstEnable   = 1'b0;
  localparam logic [PosW-1:0]  RstSetpoint = 15'd12800;
  localparam logic [PosW-1:0]  RstDeadband = 15'd256;
  localparam logic [GainW-1:0] RstGain     = 16'd256;
  localparam logic [StepW-1:0] RstMaxSteps = 16'd100;
  localparam logic [IntervalW-1:0] RstInterval = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_SETPOINT0 = 3'd1,
    CFG_SETPOINT1 = 3'd2,
    CFG_DEADBAND  = 3'd3,
    CFG_GAIN      = 3'd4,
    CFG_MAX_STEPS = 3'd5,
    CFG_INTERVAL  = 3'd6
  } cfg_idx_e;

  // Verdict of the control law for one sample
  typedef struct packed {
    logic             pass;   // outside deadband and a nonzero saturated count
    logic [StepW-1:0] steps;  // saturated step magnitude
    logic             neg;    // error negative: counterclockwise
  } law_t;

endpackage

`default_nettype wire

FILE: hdl/dbspc_if.sv
// ----------------------------------------------------------------------------
// dbspc_sample_if / dbspc_cmd_if
// Valid/ready channels for position samples and step commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbspc_sample_if
  import dbspc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [AxisW-1:0] axis;
  logic [PosW-1:0]  position;
  logic [TimeW-1:0] timestamp;
  logic             motor_ready;

  modport source (output valid, axis, position, timestamp, motor_ready, input ready);
  modport sink   (input valid, axis, position, timestamp, motor_ready, output ready);
endinterface

interface dbspc_cmd_if
  import dbspc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [AxisW-1:0] target_axis;
  logic [StepW-1:0] step_count;
  logic             direction;

  modport source (output valid, target_axis, step_count, direction, input ready);
  modport sink   (input valid, target_axis, step_count, direction, output ready);
endinterface

`default_nettype wire

FILE: hdl/dbspc_law.sv
// ----------------------------------------------------------------------------
// dbspc_law
// Proportional law: error, deadband test, rounded scaling and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module dbspc_law
  import dbspc_pkg::*;
(
  input  logic [PosW-1:0]  setpoint_i,
  input  logic [PosW-1:0]  position_i,
  input  logic [PosW-1:0]  deadband_i,
  input  logic [GainW-1:0] gain_i,
  input  logic [StepW-1:0] max_steps_i,
  output law_t             law_o
);

  logic [PosW:0]          err;
  logic                   neg;
  logic [PosW-1:0]        mag;
  logic [PosW+GainW-1:0]  prod;
  logic [PosW+GainW:0]    rnd;
  logic [StepW-1:0]       steps;
  logic [StepW-1:0]       sat;

  always_comb begin
    err   = {1'b0, setpoint_i} - {1'b0, position_i};
    neg   = err[PosW];
    mag   = neg ? PosW'(-err) : err[PosW-1:0];
    prod  = mag * gain_i;
    // round half away from zero on the magnitude
    rnd   = {1'b0, prod} + (PosW+GainW+1)'(32768);
    steps = rnd[16 +: StepW];
    sat   = (steps > max_steps_i) ? max_steps_i : steps;
    law_o.pass  = (mag >= deadband_i) && (steps != '0) && (sat != '0);
    law_o.steps = sat;
    law_o.neg   = neg;
  end

endmodule

`default_nettype wire

FILE: hdl/deadband_step_position_controller.sv
// ----------------------------------------------------------------------------
// deadband_step_position_controller
// Deadband proportional position controller issuing stepper commands.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Handshake       Payload
//  sample_i   in   valid/ready     axis, position, timestamp, motor_ready
//  command_o  out  valid/ready     target_axis, step_count, direction
//  cfg_*      in   write enable    cfg_idx_i, cfg_data_i
//
//  One sample is taken every cycle unless a held command stalls the input register;
//  a command follows its sample transaction through the input register, then the result register.
//  The per-axis time of the last command is read and written in the cycle
//  the sample leaves the input register, so consecutive samples see it.
//  A held command stalls only the input register; the sample port keeps
//  taking transactions while that register is free or advancing.
//  Reset clears control state and loads the register defaults at once.
// ----------------------------------------------------------------------------
`default_nettype none

module deadband_step_position_controller
  import dbspc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  dbspc_sample_if.sink        sample_i,
  dbspc_cmd_if.source         command_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                 enable_q;
  logic [PosW-1:0]      setpoint0_q;
  logic [PosW-1:0]      setpoint1_q;
  logic [PosW-1:0]      deadband_q;
  logic [GainW-1:0]     gain_q;
  logic [StepW-1:0]     max_steps_q;
  logic [IntervalW-1:0] interval_q;
  logic [PosW-1:0]      sp_wr;

  // clamp setpoint writes to 100 percent
  assign sp_wr = (cfg_data_i[PosW-1:0] > SetpointMax) ? SetpointMax : cfg_data_i[PosW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= RstEnable;
      setpoint0_q <= RstSetpoint;
      setpoint1_q <= RstSetpoint;
      deadband_q  <= RstDeadband;
      gain_q      <= RstGain;
      max_steps_q <= RstMaxSteps;
      interval_q  <= RstInterval;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:    enable_q    <= cfg_data_i[0];
        CFG_SETPOINT0: setpoint0_q <= sp_wr;
        CFG_SETPOINT1: setpoint1_q <= sp_wr;
        CFG_DEADBAND:  deadband_q  <= cfg_data_i[PosW-1:0];
        CFG_GAIN:      gain_q      <= cfg_data_i[GainW-1:0];
        CFG_MAX_STEPS: max_steps_q <= cfg_data_i[StepW-1:0];
        CFG_INTERVAL:  interval_q  <= cfg_data_i[IntervalW-1:0];
        default:       ; // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic             s1_v_q;
  logic [AxisW-1:0] s1_axis_q;
  logic [PosW-1:0]  s1_pos_q;
  logic [TimeW-1:0] s1_ts_q;
  logic             s1_rdy_q;
  logic             s1_go;
  logic             out_v_q;

  // the input register moves on whenever the result register is free or drained
  assign s1_go          = !out_v_q || command_o.ready;
  assign sample_i.ready = !s1_v_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_v_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      s1_axis_q <= sample_i.axis;
      s1_pos_q  <= sample_i.position;
      s1_ts_q   <= sample_i.timestamp;
      s1_rdy_q  <= sample_i.motor_ready;
    end
  end

  // --------------------------------------------------------------------------
  // Control law and rate limit
  // --------------------------------------------------------------------------
  logic [TimeW-1:0] last_q [NumAxes];
  logic [TimeW-1:0] elapsed;
  logic             axis_ok;
  logic             interval_ok;
  logic             fire;
  logic [PosW-1:0]  setpoint;
  law_t             law;

  assign setpoint = (s1_axis_q == AxisW'(0)) ? setpoint0_q : setpoint1_q;

  dbspc_law u_law (
    .setpoint_i  (setpoint),
    .position_i  (s1_pos_q),
    .deadband_i  (deadband_q),
    .gain_i      (gain_q),
    .max_steps_i (max_steps_q),
    .law_o       (law)
  );

  always_comb begin
    axis_ok     = (32'(s1_axis_q) < NumAxes);
    // wrapping difference since the last command on this axis
    elapsed     = s1_ts_q - last_q[s1_axis_q];
    interval_ok = (elapsed >= TimeW'(interval_q));
    fire        = s1_v_q && axis_ok && enable_q && law.pass && interval_ok && s1_rdy_q;
  end

  // record the time of each issued command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAxes; i++) begin
        last_q[i] <= '0;
      end
    end else if (s1_go && fire) begin
      last_q[s1_axis_q] <= s1_ts_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic             out_v_d;
  logic [AxisW-1:0] out_axis_q;
  logic [StepW-1:0] out_steps_q;
  logic             out_dir_q;

  // load a new command or drop the slot when the sample yields none; hold on stall
  assign out_v_d = s1_go ? fire : out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && fire) begin
      out_axis_q  <= s1_axis_q;
      out_steps_q <= law.steps;
      out_dir_q   <= law.neg;
    end
  end

  assign command_o.valid       = out_v_q;
  assign command_o.target_axis = out_axis_q;
  assign command_o.step_count  = out_steps_q;
  assign command_o.direction   = out_dir_q;

endmodule

`default_nettype wire

FILE: hdl/dbspc_checker.sv
// ----------------------------------------------------------------------------
// dbspc_checker
// Port-level checks of the position controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dbspc_checker
  import dbspc_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             in_motor_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [AxisW-1:0] out_axis_i,
  input wire logic [StepW-1:0] out_steps_i,
  input wire logic             out_dir_i
);

  // a stalled command holds its payload
  `DBSPC_ASSERT_NXT(a_hold_on_stall, clk_i, rst_ni,
                    out_valid_i && !out_ready_i,
                    out_valid_i && $stable(out_axis_i) && $stable(out_steps_i) &&
                    $stable(out_dir_i))

  // a command never carries a zero step count
  `DBSPC_ASSERT_IMP(a_nonzero_steps, clk_i, rst_ni, out_valid_i, out_steps_i != '0)

  // a fresh command comes from a sample taken with the motor ready, through the input and result registers
  `DBSPC_ASSERT_IMP(a_cmd_origin, clk_i, rst_ni,
                    $rose(out_valid_i),
                    $past(in_valid_i && in_ready_i && in_motor_ready_i, 2))

endmodule

bind deadband_step_position_controller dbspc_checker u_dbspc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (sample_i.valid),
  .in_ready_i       (sample_i.ready),
  .in_motor_ready_i (sample_i.motor_ready),
  .out_valid_i      (command_o.valid),
  .out_ready_i      (command_o.ready),
  .out_axis_i       (command_o.target_axis),
  .out_steps_i      (command_o.step_count),
  .out_dir_i        (command_o.direction)
);

`default_nettype wire
